[design/tcqs_pkg.sv]
// shared types and constants of the text cnn query scorer
package tcqs_pkg;
    localparam int unsigned VOCAB_SIZE_DEF  = 1024;
    localparam int unsigned NUM_FILTERS_DEF = 128;
    localparam int unsigned PAD_LEN_DEF     = 12;
    localparam int unsigned ROWS_PER_ID     = 12;
    localparam int unsigned ID_W            = 10;
    localparam int unsigned VAL_W           = 16;
    localparam int unsigned SCORE_W         = 48;
    localparam int unsigned ADDR_W          = 21;
    localparam int unsigned COUNT_W         = 16;
    localparam int unsigned SUM_W           = 20;
    localparam int unsigned ACC_W           = 56;

    localparam logic [1:0] REG_UNKNOWN_ID = 2'd0;
    localparam logic [1:0] REG_PAD_ID     = 2'd1;
    localparam logic [1:0] REG_BIAS_ZERO  = 2'd2;
    localparam logic [1:0] REG_BIAS_ONE   = 2'd3;

    localparam logic [1:0] SEL_PARTIAL = 2'd0;
    localparam logic [1:0] SEL_FBIAS   = 2'd1;
    localparam logic [1:0] SEL_WZERO   = 2'd2;
    localparam logic [1:0] SEL_WONE    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TAP,
        ST_TAP_LAST,
        ST_WIN_END,
        ST_FILT_BIAS,
        ST_FILT_MUL,
        ST_FILT_ACC,
        ST_FINAL,
        ST_OUT
    } tcqs_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_acc;    // zero both scores
        logic clear_sum;    // start a new window sum
        logic add_tap;      // add the registered partial into the sum
        logic take_best;    // compare the sum with the best so far
        logic first_win;    // first window of a filter
        logic add_bias;     // add filter bias to best
        logic mul;          // register both products
        logic acc;          // accumulate products
        logic finish;       // add output biases and saturate
    } tcqs_cmd_t;
endpackage

[design/tcqs_datapath.sv]
// datapath: tables, token window, window sums, max and dense accumulation
module tcqs_datapath
    import tcqs_pkg::*;
#(
    parameter int unsigned VOCAB_SIZE  = VOCAB_SIZE_DEF,
    parameter int unsigned NUM_FILTERS = NUM_FILTERS_DEF,
    parameter int unsigned PAD_LEN     = PAD_LEN_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // table writes
    input  logic                      tbl_we,
    input  logic [1:0]                tbl_sel,
    input  logic [ADDR_W-1:0]         tbl_addr,
    input  logic signed [VAL_W-1:0]   tbl_val,
    // token entry
    input  logic                      tok_we,
    input  logic [ID_W-1:0]           tok_id,
    input  logic                      tok_known,
    input  logic                      tok_clear,
    input  logic [ID_W-1:0]           unknown_id,
    input  logic [ID_W-1:0]           pad_id,
    input  logic signed [SCORE_W-1:0] bias_zero,
    input  logic signed [SCORE_W-1:0] bias_one,
    // scoring control
    input  tcqs_cmd_t                 cmd,
    input  logic [$clog2(PAD_LEN)-1:0] slot_idx,
    input  logic [$clog2(ROWS_PER_ID)-1:0] row_idx,
    input  logic [$clog2(3*NUM_FILTERS)-1:0] col_idx,
    input  logic [$clog2(NUM_FILTERS + 1)-1:0] filt_idx,
    output logic [COUNT_W-1:0]        token_count,
    output logic                      pass,
    output logic signed [SCORE_W-1:0] score_zero,
    output logic signed [SCORE_W-1:0] score_one
);
    localparam int unsigned COL_DEPTH = 3 * NUM_FILTERS;
    localparam int unsigned COL_W     = $clog2(COL_DEPTH);
    localparam longint unsigned PART_DEPTH =
        longint'(VOCAB_SIZE) * ROWS_PER_ID * NUM_FILTERS;
    localparam int unsigned PART_W    = $clog2(PART_DEPTH);
    localparam int unsigned SLOT_W    = $clog2(PAD_LEN);
    localparam int unsigned HIT_W     = $clog2(PAD_LEN + 1);
    localparam int unsigned RF_W      = $clog2(ROWS_PER_ID * NUM_FILTERS);

    logic signed [VAL_W-1:0] part_mem [PART_DEPTH];
    logic signed [VAL_W-1:0] fbias_mem [COL_DEPTH];
    logic signed [VAL_W-1:0] wzero_mem [COL_DEPTH];
    logic signed [VAL_W-1:0] wone_mem [COL_DEPTH];

    logic [ID_W-1:0]    window_reg [PAD_LEN];
    logic [COUNT_W-1:0] count_reg;
    logic [HIT_W-1:0]   hit_reg;

    // table writes
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            case (tbl_sel)
                SEL_PARTIAL: begin
                    if (longint'(tbl_addr) < longint'(PART_DEPTH))
                        part_mem[tbl_addr[PART_W-1:0]] <= tbl_val;
                end
                SEL_FBIAS: begin
                    if (tbl_addr < ADDR_W'(COL_DEPTH))
                        fbias_mem[tbl_addr[COL_W-1:0]] <= tbl_val;
                end
                SEL_WZERO: begin
                    if (tbl_addr < ADDR_W'(COL_DEPTH))
                        wzero_mem[tbl_addr[COL_W-1:0]] <= tbl_val;
                end
                SEL_WONE: begin
                    if (tbl_addr < ADDR_W'(COL_DEPTH))
                        wone_mem[tbl_addr[COL_W-1:0]] <= tbl_val;
                end
                default: ;
            endcase
        end
    end

    // token window
    always_ff @(posedge aclk) begin
        if (!aresetn || tok_clear) begin
            count_reg <= '0;
            hit_reg   <= '0;
            for (int i = 0; i < PAD_LEN; i++) window_reg[i] <= '0;
        end else if (tok_we) begin
            if (count_reg < COUNT_W'(PAD_LEN)) begin
                window_reg[count_reg[SLOT_W-1:0]] <= tok_known ? tok_id : unknown_id;
                if (tok_known) hit_reg <= hit_reg + 1'b1;
            end
            if (count_reg != '1) count_reg <= count_reg + 1'b1;
        end
    end

    assign token_count = count_reg;
    assign pass = ((COUNT_W+2)'(hit_reg) * (COUNT_W+2)'(5)) >
                  ((COUNT_W+2)'(count_reg) * (COUNT_W+2)'(3));

    // partial address: id * rows * filters + row * filters + filter
    logic [ID_W-1:0] slot_id;
    logic [RF_W-1:0] row_off;
    logic [PART_W+ID_W:0] part_addr;
    logic            part_ok_reg;
    logic signed [VAL_W-1:0] part_q_reg;

    assign slot_id  = (COUNT_W'(slot_idx) < count_reg) ? window_reg[slot_idx] : pad_id;
    assign row_off  = RF_W'(row_idx) * RF_W'(NUM_FILTERS) + RF_W'(filt_idx);
    assign part_addr = (PART_W+ID_W+1)'(slot_id) * (PART_W+ID_W+1)'(ROWS_PER_ID * NUM_FILTERS)
                     + (PART_W+ID_W+1)'(row_off);

    always_ff @(posedge aclk) begin
        part_q_reg  <= part_mem[part_addr[PART_W-1:0]];
        part_ok_reg <= part_addr < (PART_W+ID_W+1)'(PART_DEPTH);
    end

    logic signed [VAL_W-1:0] fb_q_reg, w0_q_reg, w1_q_reg;
    always_ff @(posedge aclk) begin
        fb_q_reg <= fbias_mem[col_idx];
        w0_q_reg <= wzero_mem[col_idx];
        w1_q_reg <= wone_mem[col_idx];
    end

    logic signed [SUM_W-1:0] sum_reg, best_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [2*VAL_W+SUM_W-VAL_W-1:0] prod0_reg, prod1_reg;
    logic signed [ACC_W-1:0] acc0_reg, acc1_reg;
    logic signed [ACC_W-1:0] fin0, fin1;
    logic signed [SCORE_W-1:0] s0_reg, s1_reg;

    assign sum_next = sum_reg + (part_ok_reg ? SUM_W'(part_q_reg) : '0);

    always_ff @(posedge aclk) begin
        if (cmd.clear_sum) sum_reg <= '0;
        else if (cmd.add_tap) sum_reg <= sum_next;
        if (cmd.take_best && (cmd.first_win || sum_reg > best_reg)) best_reg <= sum_reg;
        else if (cmd.add_bias) best_reg <= best_reg + SUM_W'(fb_q_reg);
        if (cmd.mul) begin
            prod0_reg <= best_reg * w0_q_reg;
            prod1_reg <= best_reg * w1_q_reg;
        end
        if (cmd.clear_acc) begin
            acc0_reg <= '0;
            acc1_reg <= '0;
        end else if (cmd.acc) begin
            acc0_reg <= acc0_reg + ACC_W'(prod0_reg);
            acc1_reg <= acc1_reg + ACC_W'(prod1_reg);
        end
    end

    function automatic logic signed [SCORE_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi, lo;
        hi = ACC_W'({1'b0, {(SCORE_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) return SCORE_W'(hi);
        if (v < lo) return SCORE_W'(lo);
        return v[SCORE_W-1:0];
    endfunction

    assign fin0 = acc0_reg + ACC_W'(bias_zero);
    assign fin1 = acc1_reg + ACC_W'(bias_one);

    always_ff @(posedge aclk) begin
        if (cmd.clear_acc) begin
            s0_reg <= '0;
            s1_reg <= '0;
        end else if (cmd.finish) begin
            s0_reg <= sat48(fin0);
            s1_reg <= sat48(fin1);
        end
    end

    assign score_zero = s0_reg;
    assign score_one  = s1_reg;
endmodule

[design/tcqs_ctrl.sv]
// controller: walks widths, filters, windows and taps for one query
module tcqs_ctrl
    import tcqs_pkg::*;
#(
    parameter int unsigned NUM_FILTERS = NUM_FILTERS_DEF,
    parameter int unsigned PAD_LEN     = PAD_LEN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic                       pass,
    input  logic [COUNT_W-1:0]         token_count,
    input  logic                       out_taken,
    output logic                       busy,
    output logic                       out_valid,
    output logic                       pass_out,
    output logic                       tok_clear,
    output tcqs_cmd_t                  cmd,
    output logic [$clog2(PAD_LEN)-1:0] slot_idx,
    output logic [$clog2(ROWS_PER_ID)-1:0] row_idx,
    output logic [$clog2(3*NUM_FILTERS)-1:0] col_idx,
    output logic [$clog2(NUM_FILTERS + 1)-1:0] filt_idx
);
    localparam int unsigned COL_W  = $clog2(3 * NUM_FILTERS);
    localparam int unsigned SLOT_W = $clog2(PAD_LEN);
    localparam int unsigned ROW_W  = $clog2(ROWS_PER_ID);
    localparam int unsigned F_W    = $clog2(NUM_FILTERS + 1);

    tcqs_state_t state_reg, state_next;
    logic [1:0]       wsel_reg, wsel_next;     // width minus three
    logic [F_W-1:0]   f_reg, f_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [SLOT_W-1:0] win_reg, win_next;
    logic [2:0]       tap_reg, tap_next;
    logic [ROW_W-1:0] rbase_reg, rbase_next;
    logic             pass_reg, pass_next;
    logic             firstw_reg, firstw_next;

    logic [2:0]        width;
    logic [SLOT_W-1:0] last_start;
    logic [SLOT_W:0]   pad_minus_w;

    assign width = 3'(wsel_reg) + 3'd3;
    assign pad_minus_w = (SLOT_W+1)'(PAD_LEN) - (SLOT_W+1)'(width);
    assign last_start = (token_count < COUNT_W'(pad_minus_w)) ?
                        SLOT_W'(token_count) : SLOT_W'(pad_minus_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
        wsel_reg   <= wsel_next;
        f_reg      <= f_next;
        col_reg    <= col_next;
        win_reg    <= win_next;
        tap_reg    <= tap_next;
        rbase_reg  <= rbase_next;
        firstw_reg <= firstw_next;
    end

    assign slot_idx = win_reg + SLOT_W'(tap_reg);
    assign row_idx  = rbase_reg + ROW_W'(tap_reg);
    assign col_idx  = col_reg;
    assign filt_idx = f_reg;
    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign pass_out  = pass_reg;

    always_comb begin
        state_next  = state_reg;
        wsel_next   = wsel_reg;
        f_next      = f_reg;
        col_next    = col_reg;
        win_next    = win_reg;
        tap_next    = tap_reg;
        rbase_next  = rbase_reg;
        pass_next   = pass_reg;
        firstw_next = firstw_reg;
        cmd         = '0;
        tok_clear   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    pass_next = pass;
                    cmd.clear_acc = 1'b1;
                    wsel_next = '0; f_next = '0; col_next = '0;
                    win_next = '0; tap_next = '0; rbase_next = '0;
                    firstw_next = 1'b1;
                    cmd.clear_sum = 1'b1;
                    state_next = pass ? ST_TAP : ST_FINAL;
                end
            end
            // issue one table read per cycle, summed in the following cycle
            ST_TAP: begin
                if (tap_reg != 3'd0) cmd.add_tap = 1'b1;
                if (tap_reg == width - 3'd1) state_next = ST_TAP_LAST;
                else tap_next = tap_reg + 3'd1;
            end
            ST_TAP_LAST: begin
                cmd.add_tap = 1'b1;
                state_next = ST_WIN_END;
            end
            ST_WIN_END: begin
                cmd.take_best = 1'b1;
                cmd.first_win = firstw_reg;
                firstw_next = 1'b0;
                cmd.clear_sum = 1'b1;
                tap_next = '0;
                if (win_reg == last_start) state_next = ST_FILT_BIAS;
                else begin
                    win_next = win_reg + 1'b1;
                    state_next = ST_TAP;
                end
            end
            ST_FILT_BIAS: begin
                cmd.add_bias = 1'b1;
                state_next = ST_FILT_MUL;
            end
            ST_FILT_MUL: begin
                cmd.mul = 1'b1;
                state_next = ST_FILT_ACC;
            end
            ST_FILT_ACC: begin
                cmd.acc = 1'b1;
                win_next = '0;
                tap_next = '0;
                firstw_next = 1'b1;
                col_next = col_reg + 1'b1;
                if (f_reg == F_W'(NUM_FILTERS - 1)) begin
                    f_next = '0;
                    if (wsel_reg == 2'd2) state_next = ST_FINAL;
                    else begin
                        rbase_next = rbase_reg + ROW_W'(width);
                        wsel_next = wsel_reg + 1'b1;
                        state_next = ST_TAP;
                    end
                end else begin
                    f_next = f_reg + 1'b1;
                    state_next = ST_TAP;
                end
            end
            ST_FINAL: begin
                if (pass_reg) cmd.finish = 1'b1;
                tok_clear = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_taken) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

[design/text_cnn_query_scorer.sv]
// top level of the text cnn query scorer
// Table writes and non-final tokens are taken back to back while idle. A final token
// starts a scoring pass run by one shared sequencer: each filter window reads the
// partial table once per tap, adds the reads in a pipelined sum and then compares the
// sum with the best so far, and each filter then adds its bias, multiplies and
// accumulates. A filter of width w walks min(PAD_LEN-w, count)+1 windows; a query
// that fails the gate skips the windows and goes straight to the final step. The
// result waits in an output register until taken; no new word is accepted until then.
module text_cnn_query_scorer
    import tcqs_pkg::*;
#(
    parameter int unsigned VOCAB_SIZE  = VOCAB_SIZE_DEF,
    parameter int unsigned NUM_FILTERS = NUM_FILTERS_DEF,
    parameter int unsigned PAD_LEN     = PAD_LEN_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [SCORE_W-1:0]        cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [1:0]                s_table_select,
    input  logic [ADDR_W-1:0]         s_write_address,
    input  logic signed [VAL_W-1:0]   s_write_value,
    input  logic [ID_W-1:0]           s_token_id,
    input  logic                      s_token_known,
    input  logic                      s_token_present,
    input  logic                      s_last_token,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [SCORE_W-1:0] m_score_zero,
    output logic signed [SCORE_W-1:0] m_score_one,
    output logic                      m_passed_gate
);
    logic [ID_W-1:0]           unknown_id_reg, pad_id_reg;
    logic signed [SCORE_W-1:0] bias0_reg, bias1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unknown_id_reg <= '0;
            pad_id_reg     <= ID_W'(1);
            bias0_reg      <= '0;
            bias1_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_UNKNOWN_ID: unknown_id_reg <= cfg_data[ID_W-1:0];
                REG_PAD_ID:     pad_id_reg     <= cfg_data[ID_W-1:0];
                REG_BIAS_ZERO:  bias0_reg      <= cfg_data;
                REG_BIAS_ONE:   bias1_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    logic busy, acc_in, start, pass, tok_clear;
    logic [COUNT_W-1:0] token_count;
    tcqs_cmd_t cmd;
    logic [$clog2(PAD_LEN)-1:0] slot_idx;
    logic [$clog2(ROWS_PER_ID)-1:0] row_idx;
    logic [$clog2(3*NUM_FILTERS)-1:0] col_idx;
    logic [$clog2(NUM_FILTERS + 1)-1:0] filt_idx;
    logic start_reg;

    assign s_ready = !busy && !start_reg;
    assign acc_in  = s_valid && s_ready;

    // the window takes the final token first, scoring starts in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) start_reg <= 1'b0;
        else start_reg <= acc_in && s_kind && s_last_token;
    end
    assign start = start_reg;

    tcqs_datapath #(
        .VOCAB_SIZE(VOCAB_SIZE), .NUM_FILTERS(NUM_FILTERS), .PAD_LEN(PAD_LEN)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .tbl_we(acc_in && !s_kind), .tbl_sel(s_table_select),
        .tbl_addr(s_write_address), .tbl_val(s_write_value),
        .tok_we(acc_in && s_kind && s_token_present),
        .tok_id(s_token_id), .tok_known(s_token_known), .tok_clear(tok_clear),
        .unknown_id(unknown_id_reg), .pad_id(pad_id_reg),
        .bias_zero(bias0_reg), .bias_one(bias1_reg),
        .cmd(cmd), .slot_idx(slot_idx), .row_idx(row_idx), .col_idx(col_idx),
        .filt_idx(filt_idx),
        .token_count(token_count), .pass(pass),
        .score_zero(m_score_zero), .score_one(m_score_one)
    );

    tcqs_ctrl #(.NUM_FILTERS(NUM_FILTERS), .PAD_LEN(PAD_LEN)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start), .pass(pass),
        .token_count(token_count), .out_taken(m_ready),
        .busy(busy), .out_valid(m_valid), .pass_out(m_passed_gate),
        .tok_clear(tok_clear), .cmd(cmd),
        .slot_idx(slot_idx), .row_idx(row_idx), .col_idx(col_idx),
        .filt_idx(filt_idx)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_gated_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_passed_gate) |-> (m_score_zero == '0 && m_score_one == '0))
        else $error("gated query has nonzero score");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> $past(!busy)) else $error("scoring started while busy");
`endif
endmodule

[verif/text_cnn_query_scorer_tb.sv]
// testbench of the text cnn query scorer: table loads, queries and score checks
module text_cnn_query_scorer_tb;
    import tcqs_pkg::*;

    localparam int NF       = NUM_FILTERS_DEF;
    localparam int PAD      = PAD_LEN_DEF;
    localparam int ROW_SPAN = ROWS_PER_ID * NF;
    localparam int COL_N    = 3 * NF;
    localparam int PART_N   = VOCAB_SIZE_DEF * ROW_SPAN;
    localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint S48_MIN = -S48_MAX - 1;
    localparam int WATCHDOG_LIMIT = 100000;

    typedef struct {
        bit            kind;
        bit [1:0]      sel;
        bit [20:0]     addr;
        bit [15:0]     val;
        bit [ID_W-1:0] id;
        bit            known;
        bit            present;
        bit            last;
    } word_t;

    typedef struct {
        longint s0;
        longint s1;
        bit     pass;
    } score_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_UNKNOWN_ID;
    logic [SCORE_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = 1'b0;
    logic [1:0] s_table_select = SEL_PARTIAL;
    logic [ADDR_W-1:0] s_write_address = '0;
    logic signed [VAL_W-1:0] s_write_value = '0;
    logic [ID_W-1:0] s_token_id = '0;
    logic s_token_known = 1'b0;
    logic s_token_present = 1'b0;
    logic s_last_token = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SCORE_W-1:0] m_score_zero;
    logic signed [SCORE_W-1:0] m_score_one;
    logic m_passed_gate;

    // token ids whose partial rows are loaded; together they toggle every id bit
    int unsigned id_set[8] = '{0, 1, 2, 3, 341, 682, 512, 1023};

    shortint       partials[int];
    shortint       fbias[COL_N];
    shortint       wzero[COL_N];
    shortint       wone[COL_N];
    bit [ID_W-1:0] window[PAD];
    int            tok_cnt;
    int            hits;
    bit [ID_W-1:0] unk_id = 0;
    bit [ID_W-1:0] pad_id = 1;
    longint        obias0 = 0;
    longint        obias1 = 0;

    score_t scores_q[$];
    int errors = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    bit valid_left_high = 0;
    bit hold_req = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    text_cnn_query_scorer i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_table_select(s_table_select), .s_write_address(s_write_address),
        .s_write_value(s_write_value), .s_token_id(s_token_id),
        .s_token_known(s_token_known), .s_token_present(s_token_present),
        .s_last_token(s_last_token),
        .m_valid(m_valid), .m_ready(m_ready), .m_score_zero(m_score_zero),
        .m_score_one(m_score_one), .m_passed_gate(m_passed_gate)
    );

    always #6 aclk = ~aclk;

    function automatic longint sat48(longint v);
        if (v > S48_MAX) return S48_MAX;
        if (v < S48_MIN) return S48_MIN;
        return v;
    endfunction

    function automatic longint partial_at(int unsigned id, int row, int f);
        int a;
        a = id * ROW_SPAN + row * NF + f;
        if (a >= PART_N || !partials.exists(a)) return 0;
        return partials[a];
    endfunction

    // advance the query state by one word and queue the score it causes
    function automatic void score_word(word_t w);
        score_t e;
        bit [ID_W-1:0] slot[PAD];
        longint best, sum, b;
        int last_start, row_base, c;
        if (!w.kind) begin
            if (w.sel == SEL_PARTIAL) begin
                if (w.addr < PART_N) partials[w.addr] = w.val;
            end else if (w.addr < COL_N) begin
                case (w.sel)
                    SEL_FBIAS: fbias[w.addr] = w.val;
                    SEL_WZERO: wzero[w.addr] = w.val;
                    default:   wone[w.addr] = w.val;
                endcase
            end
            return;
        end
        if (w.present) begin
            if (tok_cnt < PAD) begin
                window[tok_cnt] = w.known ? w.id : unk_id;
                if (w.known) hits++;
            end
            if (tok_cnt < 65535) tok_cnt++;
        end
        if (!w.last) return;
        e.pass = (5 * hits) > (3 * tok_cnt);
        e.s0 = 0;
        e.s1 = 0;
        if (e.pass) begin
            for (int i = 0; i < PAD; i++) slot[i] = (i < tok_cnt) ? window[i] : pad_id;
            row_base = 0;
            for (int wd = 3; wd <= 5; wd++) begin
                last_start = (tok_cnt < PAD - wd) ? tok_cnt : PAD - wd;
                for (int f = 0; f < NF; f++) begin
                    best = 0;
                    c = (wd - 3) * NF + f;
                    for (int i = 0; i <= last_start; i++) begin
                        sum = 0;
                        for (int j = 0; j < wd; j++)
                            sum += partial_at(slot[i + j], row_base + j, f);
                        if (i == 0 || sum > best) best = sum;
                    end
                    b = best + fbias[c];
                    e.s0 += b * wzero[c];
                    e.s1 += b * wone[c];
                end
                row_base += wd;
            end
            e.s0 = sat48(e.s0 + obias0);
            e.s1 = sat48(e.s1 + obias1);
        end
        scores_q.insert(scores_q.size(), e);
        foreach (window[i]) window[i] = 0;
        tok_cnt = 0;
        hits = 0;
    endfunction

    function automatic word_t rand_word();
        word_t w;
        w.kind = $urandom_range(1);
        w.sel = $urandom_range(3);
        w.addr = $urandom;
        w.val = $urandom;
        w.id = $urandom;
        w.known = $urandom_range(1);
        w.present = $urandom_range(1);
        w.last = $urandom_range(1);
        return w;
    endfunction

    function automatic word_t table_word(bit [1:0] sel, bit [20:0] addr, bit [15:0] val,
                                         bit last);
        word_t w;
        w = rand_word();
        w.kind = 1'b0;
        w.sel = sel;
        w.addr = addr;
        w.val = val;
        w.last = last;
        return w;
    endfunction

    function automatic word_t token_word(bit [ID_W-1:0] id, bit known, bit present, bit last);
        word_t w;
        w = rand_word();
        w.kind = 1'b1;
        w.id = id;
        w.known = known;
        w.present = present;
        w.last = last;
        return w;
    endfunction

    task automatic send_word(word_t w);
        int gap;
        gap = ($urandom_range(99) < snd_idle) ? $urandom_range(1, 4) : 0;
        if (gap > 0 && valid_left_high) begin
            s_valid <= 1'b0;
            valid_left_high = 0;
        end
        repeat (gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_kind <= w.kind;
        s_table_select <= w.sel;
        s_write_address <= w.addr;
        s_write_value <= w.val;
        s_token_id <= w.id;
        s_token_known <= w.known;
        s_token_present <= w.present;
        s_last_token <= w.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        score_word(w);
        valid_left_high = 1;
    endtask

    // stop offering and wait until every score has come back
    task automatic drain();
        if (valid_left_high) begin
            s_valid <= 1'b0;
            valid_left_high = 0;
            @(posedge aclk);
        end
        while (scores_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, longint data);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[47:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_UNKNOWN_ID: unk_id = data[ID_W-1:0];
            REG_PAD_ID:     pad_id = data[ID_W-1:0];
            REG_BIAS_ZERO:  obias0 = longint'(signed'(data[47:0]));
            default:        obias1 = longint'(signed'(data[47:0]));
        endcase
    endtask

    function automatic bit [ID_W-1:0] pick_id();
        return id_set[$urandom_range(7)];
    endfunction

    task automatic send_query(int len, int known_pct, bit end_empty);
        for (int i = 0; i < len; i++)
            send_word(token_word(pick_id(), $urandom_range(99) < known_pct, 1'b1,
                                 (i == len - 1) && !end_empty));
        if (end_empty || len == 0) send_word(token_word(pick_id(), 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_load_tables();
        snd_idle = 0;
        foreach (id_set[k])
            for (int a = 0; a < ROW_SPAN; a++)
                send_word(table_word(SEL_PARTIAL, id_set[k] * ROW_SPAN + a, $urandom, 1'b0));
        for (int s = SEL_FBIAS; s <= SEL_WONE; s++)
            for (int a = 0; a < COL_N; a++)
                send_word(table_word(s, a, $urandom, 1'b0));
        drain();
    endtask

    task automatic test_directed();
        // writes past the end of each table are dropped
        send_word(table_word(SEL_PARTIAL, PART_N, 16'h7FFF, 1'b0));
        send_word(table_word(SEL_PARTIAL, 21'h1F_FFFF, 16'h8000, 1'b0));
        send_word(table_word(SEL_FBIAS, COL_N, 16'h7FFF, 1'b0));
        send_word(table_word(SEL_WZERO, 21'h1F_FFFF, 16'h8000, 1'b0));
        send_word(table_word(SEL_WONE, COL_N + 1, 16'h7FFF, 1'b0));
        // table write carrying a last flag scores nothing
        send_word(table_word(SEL_FBIAS, 0, 16'h8000, 1'b1));
        send_word(table_word(SEL_WONE, COL_N - 1, 16'h7FFF, 1'b0));
        send_word(table_word(SEL_PARTIAL, 1023 * ROW_SPAN + ROW_SPAN - 1, 16'h7FFF, 1'b0));
        send_word(table_word(SEL_PARTIAL, 0, 16'h8000, 1'b0));
        send_query(0, 100, 1'b1);
        send_word(token_word(10'd0, 1'b1, 1'b1, 1'b1));
        send_word(token_word(10'd1023, 1'b1, 1'b1, 1'b1));
        send_word(token_word(10'd1023, 1'b0, 1'b1, 1'b1));
        send_query(PAD, 100, 1'b0);
        send_query(PAD + 3, 100, 1'b1);
        send_query(5, 60, 1'b0);
        send_query(4, 0, 1'b0);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_UNKNOWN_ID, 1023);
        write_reg(REG_PAD_ID, 0);
        write_reg(REG_BIAS_ZERO, S48_MAX);
        write_reg(REG_BIAS_ONE, S48_MIN);
        send_query(3, 60, 1'b0);
        send_query(8, 100, 1'b0);
        send_query(2, 100, 1'b1);
        write_reg(REG_UNKNOWN_ID, 0);
        write_reg(REG_PAD_ID, 1023);
        write_reg(REG_BIAS_ZERO, S48_MIN);
        write_reg(REG_BIAS_ONE, S48_MAX);
        send_query(6, 80, 1'b0);
        send_query(1, 100, 1'b0);
    endtask

    task automatic test_random(int n);
        int r, sent, len;
        bit empty_end;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 75) begin
                r = $urandom_range(99);
                if (r < 5) len = 0;
                else if (r < 85) len = $urandom_range(1, PAD);
                else len = $urandom_range(PAD + 1, PAD + 8);
                empty_end = (len == 0) || ($urandom_range(99) < 20);
                send_query(len, $urandom_range(40, 100), empty_end);
                sent += len + (empty_end ? 1 : 0);
            end else if (r < 88) begin
                // rewrite a loaded entry, or a write anywhere
                if ($urandom_range(1))
                    send_word(table_word(SEL_PARTIAL, pick_id() * ROW_SPAN +
                                         $urandom_range(ROW_SPAN - 1), $urandom,
                                         $urandom_range(1)));
                else
                    send_word(table_word($urandom_range(3),
                                         $urandom_range(1) ? $urandom_range(COL_N - 1) : $urandom,
                                         $urandom, $urandom_range(1)));
                sent++;
            end else begin
                // broken sequence: stray empty words and stray tokens, none of them final
                send_word(token_word(pick_id(), $urandom_range(1), $urandom_range(1), 1'b0));
                sent++;
            end
        end
    endtask

    task automatic test_random_config();
        write_reg(REG_UNKNOWN_ID, pick_id());
        write_reg(REG_PAD_ID, pick_id());
        write_reg(REG_BIAS_ZERO, $urandom_range(1) ? longint'($signed($urandom)) << 8 : 0);
        write_reg(REG_BIAS_ONE, longint'($signed($urandom)));
    endtask

    task automatic test_backpressure();
        drain();
        hold_req <= 1'b1;
        for (int q = 0; q < 4; q++) send_query($urandom_range(1, 4), 100, 1'b0);
        drain();
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // result side: random stalls and one long hold-off on request, counted from
    // the first pending result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            m_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req) begin
            m_ready <= 1'b0;
            if (m_valid) begin
                hold_cnt <= 400;
                hold_req <= 1'b0;
            end
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        score_t e;
        if (aresetn && m_valid && m_ready) begin
            if (scores_q.size() == 0) begin
                report("unexpected word", m_passed_gate, 0);
            end else begin
                e = scores_q.pop_front();
                if (longint'(m_score_zero) != e.s0) report("score_zero", m_score_zero, e.s0);
                if (longint'(m_score_one) != e.s1) report("score_one", m_score_one, e.s1);
                if (m_passed_gate != e.pass) report("passed_gate", m_passed_gate, e.pass);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("** text_cnn_query_scorer: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_tables();
        snd_idle = 14;
        rcv_idle = 53;
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_config();
        test_random(170);
        snd_idle = 53;
        rcv_idle = 14;
        test_random_config();
        test_random(170);
        snd_idle = 0;
        rcv_idle = 0;
        write_reg(REG_UNKNOWN_ID, 0);
        write_reg(REG_PAD_ID, 1);
        write_reg(REG_BIAS_ZERO, 0);
        write_reg(REG_BIAS_ONE, 0);
        test_random(160);
        drain();
        if (scores_q.size() == 0 && errors == 0) begin
            $display("** text_cnn_query_scorer: PASSED **");
        end else begin
            $display("** text_cnn_query_scorer: FAILED **");
        end
        $finish;
    end
endmodule

[sim.f]
design/tcqs_pkg.sv
design/tcqs_datapath.sv
design/tcqs_ctrl.sv
design/text_cnn_query_scorer.sv
verif/text_cnn_query_scorer_tb.sv
